### rtl/utf8_to_codepoint_decoder_assert.svh
// Assertion macros for the UTF-8 decoder modules.
// Every macro samples on clk_i and is disabled while rst_ni is low.
// Synthesis builds see empty macro bodies.
`ifndef UTF8_TO_CODEPOINT_DECODER_ASSERT_SVH
`define UTF8_TO_CODEPOINT_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons must hold too.
`define U2C_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the cycle after.
`define U2C_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define U2C_ASSERT_NOW(lbl, ante, cons, msg)
`define U2C_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/u2c_pkg.sv
// Shared types, constants and the lead-byte decode function of the UTF-8 decoder.
// Used by u2c_front, u2c_queue, u2c_back and utf8_to_codepoint_decoder.
// No dependencies.
`default_nettype none

package u2c_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [CpWidth-1:0] ReplChar = 21'h00FFFD;

  localparam logic [7:0] AsciiMax   = 8'h7F;
  localparam logic [7:0] PayloadMsk = 8'h3F;
  localparam logic [7:0] TrailLo    = 8'h80;
  localparam logic [7:0] TrailHi    = 8'hBF;
  localparam logic [7:0] TrailE0Lo  = 8'hA0;
  localparam logic [7:0] TrailF0Lo  = 8'h90;
  localparam logic [7:0] TrailEdHi  = 8'h9F;
  localparam logic [7:0] TrailF4Hi  = 8'h8F;

  localparam logic [7:0] Lead2Lo = 8'hC2;
  localparam logic [7:0] Lead2Hi = 8'hDF;
  localparam logic [7:0] Lead3Lo = 8'hE0;
  localparam logic [7:0] Lead3Hi = 8'hEF;
  localparam logic [7:0] Lead4Lo = 8'hF0;
  localparam logic [7:0] Lead4Hi = 8'hF4;
  localparam logic [7:0] LeadEd  = 8'hED;

  typedef enum logic [1:0] {
    LEAD_ASCII,
    LEAD_BAD,
    LEAD_OPEN
  } lead_kind_e;

  // Outcome of decoding one byte as a lead byte
  typedef struct packed {
    lead_kind_e         kind;
    logic [1:0]         rem;
    logic [7:0]         tmin;
    logic [7:0]         tmax;
    logic [CpWidth-1:0] partial;
  } lead_t;

  // One input byte's worth of results (one or two)
  typedef struct packed {
    logic [CpWidth-1:0] cp0;
    logic               repl0;
    logic               has1;
    logic [CpWidth-1:0] cp1;
    logic               repl1;
    logic               in_seq;
  } step_t;

  function automatic lead_t decode_lead(logic [7:0] b);
    lead_t r;
    r.kind    = LEAD_BAD;
    r.rem     = 2'd0;
    r.tmin    = TrailLo;
    r.tmax    = TrailHi;
    r.partial = '0;
    priority if (b <= AsciiMax) begin
      r.kind = LEAD_ASCII;
    end else if (b >= Lead2Lo && b <= Lead2Hi) begin
      r.kind    = LEAD_OPEN;
      r.rem     = 2'd1;
      r.partial = {16'd0, b[4:0]};
    end else if (b >= Lead3Lo && b <= Lead3Hi) begin
      r.kind    = LEAD_OPEN;
      r.rem     = 2'd2;
      r.partial = {17'd0, b[3:0]};
    end else if (b >= Lead4Lo && b <= Lead4Hi) begin
      r.kind    = LEAD_OPEN;
      r.rem     = 2'd3;
      r.partial = {18'd0, b[2:0]};
    end else begin
      r.kind = LEAD_BAD;
    end
    // Narrowed first-trailer ranges (overlongs, surrogates and values above U+10FFFF)
    if (b == Lead3Lo) begin
      r.tmin = TrailE0Lo;
    end
    if (b == LeadEd) begin
      r.tmax = TrailEdHi;
    end
    if (b == Lead4Lo) begin
      r.tmin = TrailF0Lo;
    end
    if (b == Lead4Hi) begin
      r.tmax = TrailF4Hi;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/u2c_front.sv
// Front end: holds the sequence state and classifies each byte into a step record.
// Depends on u2c_pkg.
`default_nettype none

module u2c_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          take_i,     // byte accepted this cycle
  input  wire logic [7:0]    in_byte_i,
  output u2c_pkg::step_t     step_o,
  output logic               has_result_o
);

  `include "utf8_to_codepoint_decoder_assert.svh"

  logic [u2c_pkg::CpWidth-1:0] partial_q, partial_d;
  logic [1:0]                  rem_q, rem_d;
  logic [7:0]                  tmin_q, tmin_d;
  logic [7:0]                  tmax_q, tmax_d;

  u2c_pkg::lead_t lead;
  logic           bad_trail;

  assign lead      = u2c_pkg::decode_lead(in_byte_i);
  assign bad_trail = (in_byte_i < tmin_q) || (in_byte_i > tmax_q);

  // Per-byte decode step
  always_comb begin
    partial_d    = partial_q;
    rem_d        = rem_q;
    tmin_d       = tmin_q;
    tmax_d       = tmax_q;
    has_result_o = 1'b0;
    step_o       = '0;

    if (rem_q == 2'd0 || bad_trail) begin
      // Result slot for the lead decode: second slot after a broken sequence
      if (rem_q != 2'd0) begin
        has_result_o = 1'b1;
        step_o.cp0   = u2c_pkg::ReplChar;
        step_o.repl0 = 1'b1;
        rem_d        = 2'd0;
      end
      unique case (lead.kind)
        u2c_pkg::LEAD_ASCII, u2c_pkg::LEAD_BAD: begin
          if (rem_q != 2'd0) begin
            step_o.has1  = 1'b1;
            step_o.cp1   = (lead.kind == u2c_pkg::LEAD_ASCII) ?
                           {13'd0, in_byte_i} : u2c_pkg::ReplChar;
            step_o.repl1 = (lead.kind == u2c_pkg::LEAD_BAD);
          end else begin
            has_result_o = 1'b1;
            step_o.cp0   = (lead.kind == u2c_pkg::LEAD_ASCII) ?
                           {13'd0, in_byte_i} : u2c_pkg::ReplChar;
            step_o.repl0 = (lead.kind == u2c_pkg::LEAD_BAD);
          end
        end
        u2c_pkg::LEAD_OPEN: begin
          partial_d = lead.partial;
          rem_d     = lead.rem;
          tmin_d    = lead.tmin;
          tmax_d    = lead.tmax;
        end
        default: begin
          has_result_o = 1'b1;
          step_o.cp0   = u2c_pkg::ReplChar;
          step_o.repl0 = 1'b1;
        end
      endcase
    end else begin
      // Good trailer: shift in six payload bits
      partial_d = {partial_q[u2c_pkg::CpWidth-7:0], in_byte_i[5:0]};
      tmin_d    = u2c_pkg::TrailLo;
      tmax_d    = u2c_pkg::TrailHi;
      rem_d     = rem_q - 2'd1;
      if (rem_q == 2'd1) begin
        has_result_o = 1'b1;
        step_o.cp0   = partial_d;
      end
    end
    step_o.in_seq = (rem_d != 2'd0);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= 2'd0;
    end else if (take_i) begin
      rem_q <= rem_d;
    end
  end

  // Sequence payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      tmin_q    <= 8'd0;
      tmax_q    <= 8'd0;
    end else if (take_i) begin
      partial_q <= partial_d;
      tmin_q    <= tmin_d;
      tmax_q    <= tmax_d;
    end
  end

  // Open sequence always has a nonempty trailer window inside 80..BF
  `U2C_ASSERT_NOW(a_trail_window, rem_q != 2'd0,
    tmin_q <= tmax_q && tmin_q >= u2c_pkg::TrailLo && tmax_q <= u2c_pkg::TrailHi,
    "trailer window invalid while sequence open")
  // A second result only ever follows a replacement
  `U2C_ASSERT_NOW(a_second_after_repl, take_i && has_result_o && step_o.has1,
    step_o.repl0 && step_o.cp0 == u2c_pkg::ReplChar,
    "second result without leading replacement")

endmodule

`default_nettype wire

### rtl/u2c_queue.sv
// Short queue of step records between the front and back ends.
// Depends on u2c_pkg.
`default_nettype none

module u2c_queue #(
  parameter int unsigned Depth = u2c_pkg::QueueDepthDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      wr_i,
  input  u2c_pkg::step_t wdata_i,
  input  wire logic      rd_i,
  output u2c_pkg::step_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  `include "utf8_to_codepoint_decoder_assert.svh"

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  u2c_pkg::step_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `U2C_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= FullCnt, "queue count over depth")
  `U2C_ASSERT_NOW(a_no_overflow, wr_i, !full_o, "write into full queue")

endmodule

`default_nettype wire

### rtl/u2c_back.sv
// Back end: walks the results of the head step record and presents them one per item.
// Depends on u2c_pkg.
`default_nettype none

module u2c_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  u2c_pkg::step_t                   head_i,
  input  wire logic                        q_empty_i,
  output logic                             q_rd_o,
  input  wire logic                        pop_i,
  output logic                             empty_o,
  output logic [u2c_pkg::CpWidth-1:0]      code_point_o,
  output logic                             is_replacement_o,
  output logic                             last_of_byte_o,
  output logic                             in_sequence_o
);

  `include "utf8_to_codepoint_decoder_assert.svh"

  logic sel_q, sel_d;   // 1 while the second result of the head is shown
  logic take;

  assign empty_o          = q_empty_i;
  assign take             = pop_i && !q_empty_i;
  assign code_point_o     = sel_q ? head_i.cp1 : head_i.cp0;
  assign is_replacement_o = sel_q ? head_i.repl1 : head_i.repl0;
  assign last_of_byte_o   = sel_q || !head_i.has1;
  assign in_sequence_o    = head_i.in_seq;
  assign q_rd_o           = take && last_of_byte_o;

  // Result index within the head record
  always_comb begin
    sel_d = sel_q;
    if (take) begin
      sel_d = !last_of_byte_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else begin
      sel_q <= sel_d;
    end
  end

  `U2C_ASSERT_NOW(a_sel_valid, sel_q, !q_empty_i && head_i.has1,
    "second result selected without one queued")
  `U2C_ASSERT_NEXT(a_sel_advance, take && !sel_q && head_i.has1, sel_q,
    "first of two results popped without advancing")

endmodule

`default_nettype wire

### rtl/utf8_to_codepoint_decoder.sv
// Top level of the UTF-8 to code point decoder: front end, step queue, back end.
// Depends on u2c_pkg, u2c_front, u2c_queue and u2c_back.
`default_nettype none

// Takes one UTF-8 byte per item and returns Unicode scalar values, with U+FFFD
// for malformed input. Only well-formed sequences are accepted; a trailer that
// breaks an open sequence gives U+FFFD and is then decoded again as a lead
// byte, so a byte yields zero, one or two result items. A byte is taken
// whenever the step queue (QueueDepth records) has room, so bytes stream
// at one per cycle; the back end delivers one result per cycle while any
// are queued, and a byte with two results holds its queue record for two
// pops. A byte's first result can be popped in the cycle after it is pushed.
module utf8_to_codepoint_decoder #(
  parameter int unsigned QueueDepth = u2c_pkg::QueueDepthDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [7:0]                  in_byte_i,
  output logic                             empty,
  input  wire logic                        pop,
  output logic [u2c_pkg::CpWidth-1:0]      code_point_o,
  output logic                             is_replacement_o,
  output logic                             last_of_byte_o,
  output logic                             in_sequence_o
);

  u2c_pkg::step_t step, head;
  logic           has_result, take, q_empty, q_rd;

  assign take = push && !full;

  u2c_front u_front (
    .clk_i,
    .rst_ni,
    .take_i       (take),
    .in_byte_i,
    .step_o       (step),
    .has_result_o (has_result)
  );

  u2c_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .wr_i    (take && has_result),
    .wdata_i (step),
    .rd_i    (q_rd),
    .rdata_o (head),
    .full_o  (full),
    .empty_o (q_empty)
  );

  u2c_back u_back (
    .clk_i,
    .rst_ni,
    .head_i           (head),
    .q_empty_i        (q_empty),
    .q_rd_o           (q_rd),
    .pop_i            (pop),
    .empty_o          (empty),
    .code_point_o,
    .is_replacement_o,
    .last_of_byte_o,
    .in_sequence_o
  );

endmodule

`default_nettype wire
